### src/circular_arc_step_interpolator_macros.svh
// Assertion macros for the circular arc step interpolator.
// Needs signals clk and rst_n in the scope of each use.
`ifndef CIRCULAR_ARC_STEP_INTERPOLATOR_MACROS_SVH
`define CIRCULAR_ARC_STEP_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CAI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CAI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAI_ASSERT_IMP(lbl, ante, cons, msg)
`define CAI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/cai_pkg.sv
// Shared types and constants of the circular arc step interpolator.
// No dependencies.
package cai_pkg;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned POS_W    = 22;
  localparam int unsigned ERR_W    = 48;
  localparam int unsigned PULSE_W  = 23;
  localparam int unsigned PERIOD_W = 16;

  localparam logic signed [COORD_W-1:0] COORD_HI = 12'sd1024;
  localparam logic signed [COORD_W-1:0] COORD_LO = -12'sd1024;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd40000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [2:0] {
    Q_NONE   = 3'd0,
    Q_FIRST  = 3'd1,
    Q_SECOND = 3'd2,
    Q_THIRD  = 3'd3,
    Q_FOURTH = 3'd4
  } quad_t;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] stop_x;
    logic signed [COORD_W-1:0] stop_y;
    logic                      rotate_cw;
  } cmd_t;

  // Arc setup derived from a start beat
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PULSE_W-1:0]      pulses;
    logic                    x_nonneg;
    logic                    x_nonpos;
    logic                    y_nonneg;
    logic                    y_nonpos;
  } start_t;

  typedef struct packed {
    logic                step_valid;
    logic                step_axis;
    logic                dir_pin;
    logic [PERIOD_W-1:0] period_out;
    logic                running;
    logic                all_stopped;
  } res_t;

endpackage

### src/cai_channels.sv
// Valid/ready channel interfaces: command input, step result, period write.
// Depends on cai_pkg.
interface cai_in_if;
  import cai_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] stop_x;
  logic signed [COORD_W-1:0] stop_y;
  logic                      rotate_cw;
  modport source (output valid, command, start_x, start_y, stop_x, stop_y, rotate_cw,
                  input ready);
  modport sink (input valid, command, start_x, start_y, stop_x, stop_y, rotate_cw,
                output ready);
endinterface

interface cai_out_if;
  import cai_pkg::*;
  logic                valid;
  logic                ready;
  logic                step_valid;
  logic                step_axis;
  logic                dir_pin;
  logic [PERIOD_W-1:0] period_out;
  logic                running;
  logic                all_stopped;
  modport source (output valid, step_valid, step_axis, dir_pin, period_out, running,
                  all_stopped, input ready);
  modport sink (input valid, step_valid, step_axis, dir_pin, period_out, running,
                all_stopped, output ready);
endinterface

interface cai_cfg_if;
  import cai_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] pulse_period;
  modport source (output valid, pulse_period, input ready);
  modport sink (input valid, pulse_period, output ready);
endinterface

### src/cai_start_calc.sv
// Arc setup for a start beat: clamp, scale, pulse total and start-point signs.
// Depends on cai_pkg.
module cai_start_calc #(
  parameter int SCALE = 1600
) (
  input  cai_pkg::cmd_t   cmd,
  output cai_pkg::start_t setup
);
  import cai_pkg::*;

  localparam int UW = $clog2(SCALE + 1);   // unsigned scale width
  localparam int SW = UW + 1;              // signed scale width
  localparam int PW = COORD_W + SW;        // scaled coordinate width
  localparam int DW = COORD_W + 1;         // coarse difference width
  localparam int TW = DW + 1 + UW;         // scaled total width
  localparam int XW = (TW > PULSE_W) ? TW : PULSE_W;
  localparam logic [UW-1:0] SCALE_U = UW'(SCALE);
  localparam logic signed [SW-1:0] SCALE_S = SW'(SCALE);

  logic signed [COORD_W-1:0] cx, cy, ex, ey;
  logic signed [DW-1:0]      dx, dy;
  logic [DW-1:0]             adx, ady;
  logic [DW:0]               asum;
  logic [XW-1:0]             tot;
  logic signed [PW-1:0]      px, py;

  function automatic logic signed [COORD_W-1:0] clamp(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] c;
    c = v;
    if (v > COORD_HI) c = COORD_HI;
    if (v < COORD_LO) c = COORD_LO;
    return c;
  endfunction

  always_comb begin
    cx = clamp(cmd.start_x);
    cy = clamp(cmd.start_y);
    ex = clamp(cmd.stop_x);
    ey = clamp(cmd.stop_y);
    dx = DW'(cx) - DW'(ex);
    dy = DW'(cy) - DW'(ey);
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    asum = (DW+1)'(adx) + (DW+1)'(ady);
    // |sx-ex| + |sy-ey| equals the coarse Manhattan distance times the scale
    tot = XW'(TW'(asum) * TW'(SCALE_U));
    px = PW'(cx) * PW'(SCALE_S);
    py = PW'(cy) * PW'(SCALE_S);

    setup.pos_x    = POS_W'(px);
    setup.pos_y    = POS_W'(py);
    setup.pulses   = (tot > XW'(PULSE_MAX)) ? PULSE_MAX : PULSE_W'(tot);
    // the scale is positive, so scaled signs follow the coarse ones
    setup.x_nonneg = !cx[COORD_W-1];
    setup.x_nonpos = cx[COORD_W-1] || (cx == '0);
    setup.y_nonneg = !cy[COORD_W-1];
    setup.y_nonpos = cy[COORD_W-1] || (cy == '0);
  end

endmodule

### src/cai_core.sv
// Interpolator datapath: input register, arc state, error update, result register.
// Depends on cai_pkg, cai_start_calc and the assertion macro header.
`include "circular_arc_step_interpolator_macros.svh"

module cai_core #(
  parameter int SCALE = 1600
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cai_pkg::cmd_t                  in_cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cai_pkg::res_t                  out_res,
  input  logic [cai_pkg::PERIOD_W-1:0]   period
);
  import cai_pkg::*;

  logic                    cmd_valid_r;
  cmd_t                    cmd_r;
  logic                    out_valid_r;
  res_t                    res_r, res_nxt;
  logic                    advance;

  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [PULSE_W-1:0]      pulses_r, pulses_nxt;
  quad_t                   quad_r, quad_nxt;
  logic                    run_r, run_nxt;
  logic                    cw_r, cw_nxt;

  start_t                  setup;
  logic                    dx_neg, dy_neg, use_y, sel_neg;
  logic signed [POS_W-1:0] sel_pos;
  logic [ERR_W-1:0]        twice;

  cai_start_calc #(.SCALE(SCALE)) u_start (
    .cmd   (cmd_r),
    .setup (setup)
  );

  assign advance   = cmd_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !cmd_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Direction and axis choice for a tick
  always_comb begin
    dx_neg = (quad_r == Q_FIRST) || (quad_r == Q_SECOND);
    dy_neg = (quad_r == Q_SECOND) || (quad_r == Q_THIRD);
    if ((quad_r == Q_FIRST) || (quad_r == Q_THIRD)) begin
      use_y = err_r[ERR_W-1];
    end else begin
      use_y = !err_r[ERR_W-1];
    end
    sel_pos = use_y ? pos_y_r : pos_x_r;
    sel_neg = use_y ? dy_neg : dx_neg;
    twice   = {{(ERR_W-POS_W-1){sel_pos[POS_W-1]}}, sel_pos, 1'b0};
  end

  always_comb begin
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    err_nxt    = err_r;
    pulses_nxt = pulses_r;
    quad_nxt   = quad_r;
    run_nxt    = run_r;
    cw_nxt     = cw_r;
    res_nxt    = '0;
    if (cmd_r.command == CMD_START) begin
      err_nxt    = '0;
      pos_x_nxt  = setup.pos_x;
      pos_y_nxt  = setup.pos_y;
      pulses_nxt = setup.pulses;
      run_nxt    = 1'b1;
      cw_nxt     = cmd_r.rotate_cw;
      if (!cmd_r.rotate_cw) begin
        priority if (setup.x_nonneg && setup.y_nonneg && quad_r == Q_NONE) begin
          quad_nxt = Q_FIRST;
        end else if (setup.x_nonneg && setup.y_nonpos && quad_r == Q_THIRD) begin
          quad_nxt = Q_FOURTH;
        end else if (setup.x_nonpos && setup.y_nonneg && quad_r == Q_FIRST) begin
          quad_nxt = Q_SECOND;
        end else if (setup.x_nonpos && setup.y_nonpos && quad_r == Q_SECOND) begin
          quad_nxt = Q_THIRD;
        end else begin
          quad_nxt = quad_r;
        end
      end
    end else if (pulses_r == '0) begin
      run_nxt             = 1'b0;
      res_nxt.all_stopped = (quad_r == Q_FOURTH);
    end else begin
      pulses_nxt = pulses_r - PULSE_W'(1);
      if (!cw_r && quad_r != Q_NONE) begin
        // f += 2*d*p + 1, with -2p+1 written as ~(2p) + 2
        err_nxt = err_r + (sel_neg ? ~twice : twice) + (sel_neg ? ERR_W'(2) : ERR_W'(1));
        if (use_y) begin
          pos_y_nxt = dy_neg ? pos_y_r - POS_W'(1) : pos_y_r + POS_W'(1);
        end else begin
          pos_x_nxt = dx_neg ? pos_x_r - POS_W'(1) : pos_x_r + POS_W'(1);
        end
        res_nxt.step_valid = 1'b1;
        res_nxt.step_axis  = use_y;
        res_nxt.dir_pin    = use_y ? dy_neg : !dx_neg;
        res_nxt.period_out = period;
      end
    end
    res_nxt.running = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      err_r       <= '0;
      pulses_r    <= '0;
      quad_r      <= Q_NONE;
      run_r       <= 1'b0;
      cw_r        <= 1'b0;
    end else begin
      if (in_ready) begin
        cmd_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        err_r       <= err_nxt;
        pulses_r    <= pulses_nxt;
        quad_r      <= quad_nxt;
        run_r       <= run_nxt;
        cw_r        <= cw_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= in_cmd;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  `CAI_ASSERT_IMP(a_pulses_need_run, pulses_r != '0, run_r, "pulses left while stopped")
  `CAI_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_ready, !advance, "held result overwritten")
  `CAI_ASSERT_NXT(a_fourth_sticky, quad_r == Q_FOURTH, quad_r == Q_FOURTH, "left fourth quadrant")
  `CAI_ASSERT_IMP(a_step_running, out_valid_r && res_r.step_valid, res_r.running,
                  "step issued while not running")
  `CAI_ASSERT_IMP(a_stop_not_running, out_valid_r && res_r.all_stopped, !res_r.running,
                  "all_stopped while running")

endmodule

### src/circular_arc_step_interpolator.sv
// Top level of the two-axis circular arc step interpolator.
// Depends on cai_pkg, the channel interfaces and cai_core.
//
// Usage:
//   in_bus  carries one command beat: a start beat (command 0) loads a quarter
//           arc from start_x/start_y/stop_x/stop_y and rotate_cw, a tick beat
//           (command 1) asks for the next step pulse.
//   out_bus returns exactly one result beat per command beat, in order:
//           step_valid/step_axis/dir_pin/period_out for the pulse, running,
//           and all_stopped when the arc finishes in the fourth quadrant.
//   cfg_bus writes pulse_period; always ready, write only while idle.
// Path: a command beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_bus is not stalled; the tick path is
//   one 48-bit error add and a position increment between the input register
//   and the result register.
// Reset (rst_n low, synchronous) clears position, error, pulse count, quadrant
//   and run flag, and sets pulse_period to 40000.
// When out_bus stalls, the result is held and one more command beat is taken
//   into the input register; in_bus ready then drops until the result moves.
module circular_arc_step_interpolator #(
  parameter int SCALE = 1600
) (
  input logic       clk,
  input logic       rst_n,
  cai_in_if.sink    in_bus,
  cai_out_if.source out_bus,
  cai_cfg_if.sink   cfg_bus
);
  import cai_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  cmd_t                cmd;
  res_t                res;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_bus.valid) begin
      period_r <= cfg_bus.pulse_period;
    end
  end

  always_comb begin
    cmd.command   = in_bus.command;
    cmd.start_x   = in_bus.start_x;
    cmd.start_y   = in_bus.start_y;
    cmd.stop_x    = in_bus.stop_x;
    cmd.stop_y    = in_bus.stop_y;
    cmd.rotate_cw = in_bus.rotate_cw;
  end

  cai_core #(.SCALE(SCALE)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_cmd    (cmd),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (res),
    .period    (period_r)
  );

  assign out_bus.step_valid  = res.step_valid;
  assign out_bus.step_axis   = res.step_axis;
  assign out_bus.dir_pin     = res.dir_pin;
  assign out_bus.period_out  = res.period_out;
  assign out_bus.running     = res.running;
  assign out_bus.all_stopped = res.all_stopped;

endmodule
